@@ hdl/rgbhsv_pkg.sv @@
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // channel width and field widths
  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 17;

  // stream word widths, padded to whole bytes
  localparam int IN_W  = ((3 * CH_W + 7) / 8) * 8;
  localparam int OUT_W = ((HUE_W + SAT_W + CH_W + 7) / 8) * 8;

  // divider shape: quotient bits, bits retired per stage, stage count
  localparam int Q_W        = 18;
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = Q_W / STEP_BITS;
  localparam int NUM_W      = CH_W + Q_W;
  localparam int REM_W      = CH_W;

  // hue constants in 1/64 degree, saturation fraction bits
  localparam int HUE_SIXTY = 60 * 64;
  localparam int HUE_120   = 120 * 64;
  localparam int HUE_240   = 240 * 64;
  localparam int HUE_360   = 360 * 64;
  localparam int SAT_FRAC  = 16;

  // which channel holds the maximum
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } hue_sel_t;

  // restoring division, STEP_BITS quotient bits; returns {remainder, quotient bits}
  function automatic logic [REM_W+STEP_BITS-1:0] div_step(
    input logic [REM_W-1:0]     rem,
    input logic [STEP_BITS-1:0] bits,
    input logic [REM_W-1:0]     den
  );
    logic [REM_W:0]         trial;
    logic [REM_W-1:0]       r;
    logic [STEP_BITS-1:0]   q;
    r = rem;
    q = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, bits[i]};
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        q[i]  = 1'b1;
      end
      r = trial[REM_W-1:0];
    end
    return {r, q};
  endfunction

endpackage

@@ hdl/rgb_to_hsv.sv @@
`timescale 1ns / 1ps

// rgb_to_hsv: converts one RGB pixel per word into hue, saturation and value.
// Input stream: in_tdata carries red, green, blue (8 bits each, red lowest).
// Output stream: out_tdata carries hue (15 bits, 1/64 degree, floored),
// saturation (17 bits, Q1.16, floored) and brightness (the largest channel).
// A grey pixel gives hue 0, a black pixel gives saturation 0; ties for the
// largest channel go to red, then green.
// Throughput: one pixel per clock while no stall holds the pipeline. From the input
// handshake to out_tvalid there is one stage for max/min, one for the hue
// numerator, nine stages of a pipelined restoring divider (two quotient
// bits per stage, hue and saturation side by side), one output register.
// Stalls: the output register is backed by a one-word skid buffer; when the
// skid holds a word the whole pipeline freezes and in_tready drops, so no
// word is lost or repeated. in_tready comes from a register only.
// Reset (rst_n low, synchronous) empties every stage; in_tready is high
// right after reset.
module rgb_to_hsv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rgbhsv_pkg::IN_W-1:0]  in_tdata,   // red, green, blue
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [rgbhsv_pkg::OUT_W-1:0] out_tdata   // hue, saturation, brightness
);
  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] h_rem;
    logic [Q_W-1:0]   h_word;
    logic [REM_W-1:0] h_den;
    logic [REM_W-1:0] s_rem;
    logic [Q_W-1:0]   s_word;
    logic [REM_W-1:0] s_den;
    logic             h_zero;
    logic             s_zero;
  } div_stage_t;

  logic en;

  // input unpack
  logic [CH_W-1:0] red, green, blue;
  assign red   = in_tdata[CH_W-1:0];
  assign green = in_tdata[2*CH_W-1:CH_W];
  assign blue  = in_tdata[3*CH_W-1:2*CH_W];

  // stage 1: max, min, difference and sector
  logic                   v1_r;
  logic [CH_W-1:0]        hi1_r, hi1_nxt;
  logic [CH_W-1:0]        delta1_r, delta1_nxt;
  logic signed [CH_W:0]   diff1_r, diff1_nxt;
  hue_sel_t               sel1_r, sel1_nxt;
  logic [CH_W-1:0]        lo_c;

  always_comb begin
    hi1_nxt = (red > green) ? red : green;
    hi1_nxt = (hi1_nxt > blue) ? hi1_nxt : blue;
    lo_c    = (red < green) ? red : green;
    lo_c    = (lo_c < blue) ? lo_c : blue;
    delta1_nxt = hi1_nxt - lo_c;
    if (hi1_nxt == red) begin
      sel1_nxt  = SEL_RED;
      diff1_nxt = {1'b0, green} - {1'b0, blue};
    end else if (hi1_nxt == green) begin
      sel1_nxt  = SEL_GREEN;
      diff1_nxt = {1'b0, blue} - {1'b0, red};
    end else begin
      sel1_nxt  = SEL_BLUE;
      diff1_nxt = {1'b0, red} - {1'b0, green};
    end
  end

  // stage 2: hue numerator 64 * hue * delta, folded into [0, 360), and saturation numerator delta << SAT_FRAC
  logic [HUE_W-1:0]       off_c;
  logic signed [NUM_W:0]  sixty_term, off_term, num_s;
  logic [NUM_W-1:0]       num_c, sat_num_c;
  div_stage_t             div0_nxt;

  always_comb begin
    case (sel1_r)
      SEL_RED:   off_c = diff1_r[CH_W] ? HUE_W'(HUE_360) : '0;
      SEL_GREEN: off_c = HUE_W'(HUE_120);
      SEL_BLUE:  off_c = HUE_W'(HUE_240);
      default:   off_c = '0;
    endcase
    sixty_term = $signed((NUM_W+1)'(HUE_SIXTY)) * $signed((NUM_W+1)'(diff1_r));
    off_term   = $signed({1'b0, NUM_W'(off_c) * NUM_W'(delta1_r)});
    num_s      = sixty_term + off_term;
    num_c      = num_s[NUM_W-1:0];
    sat_num_c  = NUM_W'(delta1_r) << SAT_FRAC;

    div0_nxt.h_rem  = num_c[NUM_W-1:Q_W];
    div0_nxt.h_word = num_c[Q_W-1:0];
    div0_nxt.h_den  = delta1_r;
    div0_nxt.s_rem  = sat_num_c[NUM_W-1:Q_W];
    div0_nxt.s_word = sat_num_c[Q_W-1:0];
    div0_nxt.s_den  = hi1_r;
    div0_nxt.h_zero = (delta1_r == '0);
    div0_nxt.s_zero = (hi1_r == '0);
  end

  // divider stages: each retires STEP_BITS quotient bits of both divisions
  logic [DIV_STAGES:0] dv_r;
  div_stage_t          div_r   [DIV_STAGES+1];
  div_stage_t          div_nxt [DIV_STAGES+1];

  always_comb begin
    logic [REM_W+STEP_BITS-1:0] hs, ss;
    div_nxt[0] = div0_nxt;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      hs = div_step(div_r[k-1].h_rem, div_r[k-1].h_word[Q_W-1 -: STEP_BITS],
                    div_r[k-1].h_den);
      ss = div_step(div_r[k-1].s_rem, div_r[k-1].s_word[Q_W-1 -: STEP_BITS],
                    div_r[k-1].s_den);
      div_nxt[k]        = div_r[k-1];
      div_nxt[k].h_rem  = hs[REM_W+STEP_BITS-1:STEP_BITS];
      div_nxt[k].h_word = {div_r[k-1].h_word[Q_W-STEP_BITS-1:0], hs[STEP_BITS-1:0]};
      div_nxt[k].s_rem  = ss[REM_W+STEP_BITS-1:STEP_BITS];
      div_nxt[k].s_word = {div_r[k-1].s_word[Q_W-STEP_BITS-1:0], ss[STEP_BITS-1:0]};
    end
  end

  // brightness travels alongside the divider
  logic [CH_W-1:0] bright_r [DIV_STAGES+1];

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      dv_r <= '0;
    end else if (en) begin
      v1_r <= in_tvalid;
      dv_r <= {dv_r[DIV_STAGES-1:0], v1_r};
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      hi1_r    <= hi1_nxt;
      delta1_r <= delta1_nxt;
      diff1_r  <= diff1_nxt;
      sel1_r   <= sel1_nxt;
      bright_r[0] <= hi1_r;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_r[k] <= div_nxt[k];
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        bright_r[k] <= bright_r[k-1];
      end
    end
  end

  // final word from the last divider stage
  logic [HUE_W-1:0]  hue_c;
  logic [SAT_W-1:0]  sat_c;
  logic [OUT_W-1:0]  word_c;
  logic              pv;

  assign pv     = dv_r[DIV_STAGES];
  assign hue_c  = div_r[DIV_STAGES].h_zero ? '0 : div_r[DIV_STAGES].h_word[HUE_W-1:0];
  assign sat_c  = div_r[DIV_STAGES].s_zero ? '0 : div_r[DIV_STAGES].s_word[SAT_W-1:0];
  assign word_c = OUT_W'({bright_r[DIV_STAGES], sat_c, hue_c});

  // output register with one-word skid buffer
  logic             out_valid_r, skid_valid_r;
  logic [OUT_W-1:0] out_data_r, skid_data_r;
  logic             out_free;

  assign en       = !skid_valid_r;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pv;
      end
    end else if (en && pv) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : word_c;
    end
    if (!out_free && en && pv) begin
      skid_data_r <= word_c;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
